// ===== rtl/core/sliding_window_throughput_meter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window throughput meter.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_THROUGHPUT_METER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_THROUGHPUT_METER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while the reset is released.
`define SWTM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("swtm assertion failed");
// Checked at every edge, also during reset.
`define SWTM_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("swtm assertion failed");
`else
`define SWTM_ASSERT(lbl, clk, rst_n, prop)
`define SWTM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/core/swtm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sliding window throughput meter package
// Shared widths, register indexes, arithmetic operations and sequencer states.
// ----------------------------------------------------------------------------
package swtm_pkg;

	localparam int unsigned AMOUNT_W   = 24;
	localparam int unsigned TIME_W     = 24;
	localparam int unsigned TOTAL_W    = 48;
	localparam int unsigned SPEED_W    = 32;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam int unsigned RING_DEPTH_DEFAULT    = 64;
	localparam int unsigned FRACTION_BITS_DEFAULT = 8;

	localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RESET = 32'd16;

	// The window counts as filled when Den * measure > Num * length.
	localparam int unsigned FILL_NUM = 9;
	localparam int unsigned FILL_DEN = 10;

	localparam logic [SPEED_W-1:0] SPEED_TIME_ZERO = 32'hffff_fffe;
	localparam logic [SPEED_W-1:0] SPEED_MAX       = 32'hffff_ffff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH,
		REG_WINDOW_UNIT
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ALU_ADD_SAT,
		ALU_SUB_FLOOR,
		ALU_SUB_TRIAL
	} alu_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_AMT,
		ST_ADD_TIME,
		ST_WRITE,
		ST_CHECK,
		ST_EV_RD,
		ST_EV_AMT,
		ST_EV_TIME,
		ST_FILL,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_DIV_DONE,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/swtm_if.sv =====
// ----------------------------------------------------------------------------
// Sliding window throughput meter channels
// Valid/ready channels for transfer samples and for speed results.
// ----------------------------------------------------------------------------
interface swtm_sample_if;
	logic                             valid;
	logic                             ready;
	logic [swtm_pkg::AMOUNT_W-1:0]    sample_amount;
	logic [swtm_pkg::TIME_W-1:0]      sample_time;

	modport source (output valid, output sample_amount, output sample_time, input ready);
	modport sink (input valid, input sample_amount, input sample_time, output ready);
endinterface

interface swtm_result_if;
	logic                             valid;
	logic                             ready;
	logic [swtm_pkg::SPEED_W-1:0]     mean_speed;
	logic                             window_filled;
	logic                             totals_saturated;

	modport source (output valid, output mean_speed, output window_filled,
		output totals_saturated, input ready);
	modport sink (input valid, input mean_speed, input window_filled,
		input totals_saturated, output ready);
endinterface

// ===== rtl/core/sliding_window_throughput_meter_core.sv =====
// ----------------------------------------------------------------------------
// Sliding window throughput meter core
// Keeps windowed totals of transfer samples and reports the mean speed.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload                                          | Handshake
//  sample   | in        | sample_amount, sample_time                       | valid/ready
//  result   | out       | mean_speed, window_filled, totals_saturated      | valid/ready
//  cfg      | in        | cfg_index, cfg_data                              | cfg_we
//
// A windowed transaction adds the sample to the totals, evicts the oldest entry first
// when the ring was full, writes the sample and then evicts entries while the window
// is exceeded, at most RING_DEPTH of them. An unwindowed transaction only adds the
// sample to the totals. The quotient is skipped when the total time is zero.
// The sample channel is ready only in the idle state. While the output register still
// holds an untaken result, the next finished result waits in the done state. Reset clears
// the totals and ring pointers and presets the configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "sliding_window_throughput_meter_core_assert.svh"

module sliding_window_throughput_meter_core #(
	parameter int unsigned RING_DEPTH    = swtm_pkg::RING_DEPTH_DEFAULT,
	parameter int unsigned FRACTION_BITS = swtm_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	swtm_sample_if.sink                       sample,
	swtm_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [swtm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [swtm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned AW      = $clog2(RING_DEPTH);
	localparam int unsigned CNT_W   = $clog2(RING_DEPTH + 1);
	localparam int unsigned SLOT_W  = AW + 1;
	localparam int unsigned AMT_W   = swtm_pkg::AMOUNT_W;
	localparam int unsigned TIM_W   = swtm_pkg::TIME_W;
	localparam int unsigned ENTRY_W = AMT_W + TIM_W;
	localparam int unsigned TW      = swtm_pkg::TOTAL_W;
	localparam int unsigned ALU_W   = TW + 1;
	localparam int unsigned SW      = swtm_pkg::SPEED_W;
	localparam int unsigned LW      = swtm_pkg::CFG_DATA_W;
	localparam int unsigned DVD_W   = TW + FRACTION_BITS;
	localparam int unsigned DCNT_W  = $clog2(DVD_W + 1);
	localparam int unsigned MW      = TW + 4;

	swtm_pkg::state_t state_q, state_d;

	logic [LW-1:0]     win_len_q;
	logic              win_unit_q;
	logic [AMT_W-1:0]  amt_q;
	logic [TIM_W-1:0]  tim_q;
	logic [TW-1:0]     tot_amt_q;
	logic [TW-1:0]     tot_time_q;
	logic [AW-1:0]     head_q;
	logic [CNT_W-1:0]  count_q;
	logic              pre_evict_q;
	logic              clamp_q;
	logic              filled_q;
	logic [SW-1:0]     speed_q;
	logic [TW-1:0]     rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              out_valid_q;
	logic [SW-1:0]     res_speed_q;
	logic              res_filled_q;
	logic              res_sat_q;

	swtm_pkg::alu_op_t alu_op;
	logic [ALU_W-1:0]  alu_a;
	logic [ALU_W-1:0]  alu_b;
	logic [ALU_W-1:0]  alu_res;
	logic              alu_flag;

	logic [ENTRY_W-1:0] rd_data;
	logic [AMT_W-1:0]   rd_amt;
	logic [TIM_W-1:0]   rd_tim;
	logic               ring_we;
	logic [SLOT_W-1:0]  slot_sum;
	logic [AW-1:0]      slot;
	logic [SLOT_W-1:0]  head_inc;
	logic [AW-1:0]      head_nx;

	logic [TW-1:0]      measure;
	logic               over_window;
	logic               fill_hit;
	logic               ring_full;
	logic               win_off;
	logic               accept;
	logic               load;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len_q  <= swtm_pkg::WINDOW_LENGTH_RESET;
			win_unit_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swtm_pkg::REG_WINDOW_LENGTH: win_len_q  <= cfg_data;
				swtm_pkg::REG_WINDOW_UNIT:   win_unit_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign accept    = sample.valid && sample.ready;
	assign load      = (state_q == swtm_pkg::ST_DONE) && (!out_valid_q || result.ready);
	assign win_off   = (win_len_q == '0);
	assign ring_full = (count_q == CNT_W'(RING_DEPTH));
	assign measure   = win_unit_q ? tot_time_q : TW'(count_q);
	assign over_window = (count_q != '0) && (measure > TW'(win_len_q));
	assign fill_hit  = (MW'(measure) * MW'(swtm_pkg::FILL_DEN)) >
		(MW'(win_len_q) * MW'(swtm_pkg::FILL_NUM));

	assign slot_sum = SLOT_W'(head_q) + SLOT_W'(count_q);
	assign slot     = (slot_sum >= SLOT_W'(RING_DEPTH)) ?
		AW'(slot_sum - SLOT_W'(RING_DEPTH)) : AW'(slot_sum);
	assign head_inc = SLOT_W'(head_q) + SLOT_W'(1);
	assign head_nx  = (head_inc >= SLOT_W'(RING_DEPTH)) ? '0 : AW'(head_inc);

	assign rd_amt = rd_data[ENTRY_W-1 -: AMT_W];
	assign rd_tim = rd_data[TIM_W-1:0];

	swtm_ring #(
		.DEPTH  (RING_DEPTH),
		.ADDR_W (AW),
		.DATA_W (ENTRY_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_we),
		.wr_addr (slot),
		.wr_data ({amt_q, tim_q}),
		.rd_addr (head_q),
		.rd_data (rd_data)
	);

	swtm_alu #(
		.W (ALU_W)
	) u_alu (
		.op   (alu_op),
		.a    (alu_a),
		.b    (alu_b),
		.res  (alu_res),
		.flag (alu_flag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swtm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, operand selection and handshake.
	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		ring_we      = 1'b0;
		alu_op       = swtm_pkg::ALU_ADD_SAT;
		alu_a        = '0;
		alu_b        = '0;
		unique case (state_q)
			swtm_pkg::ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					state_d = swtm_pkg::ST_ADD_AMT;
				end
			end
			swtm_pkg::ST_ADD_AMT: begin
				alu_a   = ALU_W'(tot_amt_q);
				alu_b   = ALU_W'(amt_q);
				state_d = swtm_pkg::ST_ADD_TIME;
			end
			swtm_pkg::ST_ADD_TIME: begin
				alu_a = ALU_W'(tot_time_q);
				alu_b = ALU_W'(tim_q);
				if (win_off) begin
					state_d = swtm_pkg::ST_DIV_INIT;
				end else if (ring_full) begin
					state_d = swtm_pkg::ST_EV_RD;
				end else begin
					state_d = swtm_pkg::ST_WRITE;
				end
			end
			swtm_pkg::ST_WRITE: begin
				ring_we = 1'b1;
				state_d = swtm_pkg::ST_CHECK;
			end
			swtm_pkg::ST_CHECK: begin
				state_d = over_window ? swtm_pkg::ST_EV_RD : swtm_pkg::ST_FILL;
			end
			swtm_pkg::ST_EV_RD: begin
				state_d = swtm_pkg::ST_EV_AMT;
			end
			swtm_pkg::ST_EV_AMT: begin
				alu_op  = swtm_pkg::ALU_SUB_FLOOR;
				alu_a   = ALU_W'(tot_amt_q);
				alu_b   = ALU_W'(rd_amt);
				state_d = swtm_pkg::ST_EV_TIME;
			end
			swtm_pkg::ST_EV_TIME: begin
				alu_op  = swtm_pkg::ALU_SUB_FLOOR;
				alu_a   = ALU_W'(tot_time_q);
				alu_b   = ALU_W'(rd_tim);
				state_d = pre_evict_q ? swtm_pkg::ST_WRITE : swtm_pkg::ST_CHECK;
			end
			swtm_pkg::ST_FILL: begin
				state_d = fill_hit ? swtm_pkg::ST_DIV_INIT : swtm_pkg::ST_DONE;
			end
			swtm_pkg::ST_DIV_INIT: begin
				state_d = (tot_time_q == '0) ? swtm_pkg::ST_DONE : swtm_pkg::ST_DIV_STEP;
			end
			swtm_pkg::ST_DIV_STEP: begin
				alu_op = swtm_pkg::ALU_SUB_TRIAL;
				alu_a  = {rem_q, dvd_q[DVD_W-1]};
				alu_b  = ALU_W'(tot_time_q);
				if (dcnt_q == DCNT_W'(1)) begin
					state_d = swtm_pkg::ST_DIV_DONE;
				end
			end
			swtm_pkg::ST_DIV_DONE: begin
				state_d = swtm_pkg::ST_DONE;
			end
			swtm_pkg::ST_DONE: begin
				if (load) begin
					state_d = swtm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swtm_pkg::ST_IDLE;
			end
		endcase
	end

	// Ring pointers and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			pre_evict_q <= 1'b0;
			clamp_q     <= 1'b0;
			filled_q    <= 1'b0;
			dcnt_q      <= '0;
		end else begin
			case (state_q)
				swtm_pkg::ST_ADD_AMT: begin
					clamp_q <= alu_flag;
				end
				swtm_pkg::ST_ADD_TIME: begin
					clamp_q     <= clamp_q | alu_flag;
					filled_q    <= 1'b0;
					pre_evict_q <= ring_full;
					if (win_off) begin
						head_q  <= '0;
						count_q <= '0;
					end
				end
				swtm_pkg::ST_WRITE: begin
					count_q     <= count_q + CNT_W'(1);
					pre_evict_q <= 1'b0;
				end
				swtm_pkg::ST_EV_TIME: begin
					head_q  <= head_nx;
					count_q <= count_q - CNT_W'(1);
				end
				swtm_pkg::ST_FILL: begin
					filled_q <= fill_hit;
				end
				swtm_pkg::ST_DIV_INIT: begin
					dcnt_q <= DCNT_W'(DVD_W);
				end
				swtm_pkg::ST_DIV_STEP: begin
					dcnt_q <= dcnt_q - DCNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Running totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_amt_q  <= '0;
			tot_time_q <= '0;
		end else begin
			case (state_q)
				swtm_pkg::ST_ADD_AMT, swtm_pkg::ST_EV_AMT: begin
					tot_amt_q <= alu_res[TW-1:0];
				end
				swtm_pkg::ST_ADD_TIME, swtm_pkg::ST_EV_TIME: begin
					tot_time_q <= alu_res[TW-1:0];
				end
				default: ;
			endcase
		end
	end

	// Sample capture and division datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			amt_q <= sample.sample_amount;
			tim_q <= sample.sample_time;
		end
		case (state_q)
			swtm_pkg::ST_FILL: begin
				speed_q <= '0;
			end
			swtm_pkg::ST_DIV_INIT: begin
				speed_q <= swtm_pkg::SPEED_TIME_ZERO;
				rem_q   <= '0;
				dvd_q   <= DVD_W'(tot_amt_q) << FRACTION_BITS;
			end
			swtm_pkg::ST_DIV_STEP: begin
				rem_q <= alu_res[TW-1:0];
				dvd_q <= {dvd_q[DVD_W-2:0], alu_flag};
			end
			swtm_pkg::ST_DIV_DONE: begin
				speed_q <= (|dvd_q[DVD_W-1:SW]) ? swtm_pkg::SPEED_MAX : dvd_q[SW-1:0];
			end
			default: ;
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_speed_q  <= speed_q;
			res_filled_q <= filled_q;
			res_sat_q    <= clamp_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.mean_speed       = res_speed_q;
	assign result.window_filled    = res_filled_q;
	assign result.totals_saturated = res_sat_q;

	`SWTM_ASSERT_ALWAYS(a_count_bound, clk, !arst_n || (count_q <= CNT_W'(RING_DEPTH)))
	`SWTM_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> !sample.ready)
	`SWTM_ASSERT(a_filled_needs_window, clk, arst_n, (load && filled_q) |-> !win_off)
	`SWTM_ASSERT(a_div_count_live, clk, arst_n, (state_q == swtm_pkg::ST_DIV_STEP) |-> (dcnt_q != '0))

endmodule

// ===== rtl/core/swtm_ring.sv =====
// ----------------------------------------------------------------------------
// Sample ring memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swtm_ring #(
	parameter int unsigned DEPTH  = swtm_pkg::RING_DEPTH_DEFAULT,
	parameter int unsigned ADDR_W = $clog2(DEPTH),
	parameter int unsigned DATA_W = swtm_pkg::AMOUNT_W + swtm_pkg::TIME_W
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/swtm_alu.sv =====
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Saturating add, floor subtract and trial subtract for one division step.
// ----------------------------------------------------------------------------
module swtm_alu #(
	parameter int unsigned W = swtm_pkg::TOTAL_W + 1
) (
	input  swtm_pkg::alu_op_t op,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic [W-1:0]      res,
	output logic              flag
);

	logic [W:0]   diff;
	logic [W-1:0] sum;
	logic         borrow;

	assign diff   = {1'b0, a} - {1'b0, b};
	assign borrow = diff[W];
	assign sum    = a + b;

	// Saturation is at all ones in the low W-1 bits; operands stay below that bound.
	always_comb begin
		res  = '0;
		flag = 1'b0;
		case (op)
			swtm_pkg::ALU_ADD_SAT: begin
				flag = sum[W-1];
				res  = sum[W-1] ? {1'b0, {(W-1){1'b1}}} : sum;
			end
			swtm_pkg::ALU_SUB_FLOOR: begin
				flag = borrow;
				res  = borrow ? '0 : diff[W-1:0];
			end
			swtm_pkg::ALU_SUB_TRIAL: begin
				flag = !borrow;
				res  = borrow ? a : diff[W-1:0];
			end
			default: begin
				res  = '0;
				flag = 1'b0;
			end
		endcase
	end

endmodule
